// File: design/ibf_pkg.sv
// Shared types, codes and helpers for the fourth-order recursive filter.
package ibf_pkg;

    localparam int SAMPLE_W = 32;
    localparam int COEF_W   = 32;
    localparam int PAIR_W   = 64;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W   = 66;
    localparam int ACC_W    = 68;
    localparam int FRAC_SHIFT = 28;
    localparam int TAP_W    = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FF01   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FF23   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FF4    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FB01   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FB23   = 3'd6;

    localparam logic [31:0] SCALE_RESET = 32'h8000_0000;

    // filter modes
    localparam logic MODE_BILINEAR = 1'b0;
    localparam logic MODE_MATCHED  = 1'b1;

    typedef logic [TAP_W-1:0] t_tap;

    // tap codes: 0..3 older inputs, 4 newest input, 5..8 previous outputs
    localparam t_tap TAP_FF0  = 4'd0;
    localparam t_tap TAP_FF1  = 4'd1;
    localparam t_tap TAP_FF2  = 4'd2;
    localparam t_tap TAP_FF3  = 4'd3;
    localparam t_tap TAP_FF4  = 4'd4;
    localparam t_tap TAP_FB0  = 4'd5;
    localparam t_tap TAP_FB1  = 4'd6;
    localparam t_tap TAP_FB2  = 4'd7;
    localparam t_tap TAP_FB3  = 4'd8;
    localparam t_tap TAP_LAST = TAP_FB3;

    typedef struct packed {
        logic load_x;       // latch the incoming sample
        logic mul_scale;    // multiply sample by input scale
        logic load_scaled;  // round scaled sample, shift input history (bilinear), seed accumulator
        logic mul_tap;      // multiply data and coefficient of the selected tap
        logic acc_add;      // add the registered product to the accumulator
        logic write_out;    // round, saturate, store output and shift output history
        t_tap tap;
    } t_dp_cmd;

    typedef struct packed {
        logic mode;
    } t_dp_sts;

    function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [39:0] v);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = 40'sd2147483647;
        lo = -40'sd2147483648;
        if (v > hi) begin
            sat32 = 32'sh7fff_ffff;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// File: design/iir_bessel_filter_order4.sv
// Top level of the fourth-order recursive filter: controller plus datapath.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------
//  in       | i_in_valid / o_in_ready   | i_sample_in (Q16.16, signed)
//  out      | o_out_valid / i_out_ready | o_sample_out (Q16.16, signed)
//  cfg      | i_cfg_wr_en               | i_cfg_addr, i_cfg_wr_data
//
// A sample passes the scale, load, tap multiply-accumulate, drain and handoff steps; the
// number of taps is 2*ORDER+1 in bilinear mode and ORDER in matched-z mode (9 and 4
// at ORDER 4); the next sample is taken only after the handoff, back in idle.
// All products go through one shared 33x33 multiplier, one a cycle.
// Reset is synchronous, active low; histories clear to zero, scale to 1.0.
// A new sample is taken while the previous result waits in the output
// register; the sequencer stalls only when the next result is done and that
// register is still full.
module iir_bessel_filter_order4 #(
    parameter int ORDER = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ibf_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [ibf_pkg::PAIR_W-1:0]          i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [ibf_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [ibf_pkg::SAMPLE_W-1:0] o_sample_out
);

    ibf_pkg::t_dp_cmd w_cmd;
    ibf_pkg::t_dp_sts w_sts;

    ibf_ctrl #(
        .ORDER (ORDER)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ibf_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sample_in   (i_sample_in),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_sample_out  (o_sample_out)
    );

endmodule

// File: design/ibf_ctrl.sv
// Sequencer for the filter: scale, tap multiply-accumulate sequence and output handoff.
module ibf_ctrl #(
    parameter int ORDER = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  ibf_pkg::t_dp_sts i_sts,
    output ibf_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCALE = 6'b000010,
        S_LOAD  = 6'b000100,
        S_MAC   = 6'b001000,
        S_DRAIN = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    localparam ibf_pkg::t_tap FIRST_BIL = ibf_pkg::TAP_FF4 - ibf_pkg::TAP_W'(ORDER);
    localparam ibf_pkg::t_tap FIRST_MZ  = ibf_pkg::TAP_LAST + 4'd1 - ibf_pkg::TAP_W'(ORDER);

    t_state        r_state, n_state;
    ibf_pkg::t_tap r_tap, n_tap;
    logic          r_acc_pend;
    logic          r_out_vld, n_out_vld;
    ibf_pkg::t_tap w_first;

    assign w_first = (i_sts.mode == ibf_pkg::MODE_MATCHED) ? FIRST_MZ : FIRST_BIL;

    always_comb begin
        n_state   = r_state;
        n_tap     = r_tap;
        o_cmd     = '0;
        o_cmd.tap = r_tap;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_x = 1'b1;
                    n_state      = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.mul_scale = 1'b1;
                n_state         = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_scaled = 1'b1;
                n_tap             = w_first;
                n_state           = S_MAC;
            end
            S_MAC: begin
                o_cmd.mul_tap = 1'b1;
                o_cmd.acc_add = r_acc_pend;
                // skip the older feedback taps that ORDER leaves out
                n_tap         = (r_tap == ibf_pkg::TAP_FF4) ? FIRST_MZ : r_tap + 4'd1;
                if (r_tap == ibf_pkg::TAP_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.acc_add = r_acc_pend;
                n_state       = S_DONE;
            end
            S_DONE: begin
                // hold the finished sum until the output register is free
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.write_out = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.write_out) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tap      <= ibf_pkg::TAP_FF0;
            r_acc_pend <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_tap      <= n_tap;
            r_acc_pend <= o_cmd.mul_tap;
            r_out_vld  <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write_out |-> (!r_out_vld || i_out_ready))
        else $error("output register overwritten while still pending");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SCALE))
        else $error("accepted sample did not start the scale step");

    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_tap >= w_first && r_tap <= ibf_pkg::TAP_LAST))
        else $error("tap index out of range");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("output became valid outside the handoff step");
`endif

endmodule

// File: design/ibf_dpath.sv
// Datapath: configuration registers, histories, shared multiplier and accumulator.
module ibf_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ibf_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [ibf_pkg::PAIR_W-1:0]          i_cfg_wr_data,
    input  logic signed [ibf_pkg::SAMPLE_W-1:0] i_sample_in,
    input  ibf_pkg::t_dp_cmd                    i_cmd,
    output ibf_pkg::t_dp_sts                    o_sts,
    output logic signed [ibf_pkg::SAMPLE_W-1:0] o_sample_out
);

    logic                              r_mode;
    logic [31:0]                       r_scale;
    logic [ibf_pkg::PAIR_W-1:0]        r_ff01, r_ff23, r_fb01, r_fb23;
    logic [ibf_pkg::COEF_W-1:0]        r_ff4;

    logic signed [ibf_pkg::SAMPLE_W-1:0] r_in_hist  [5];
    logic signed [ibf_pkg::SAMPLE_W-1:0] r_out_hist [4];
    logic signed [ibf_pkg::SAMPLE_W-1:0] r_x;
    logic signed [ibf_pkg::PROD_W-1:0]   r_prod;
    logic signed [ibf_pkg::ACC_W-1:0]    r_acc;
    logic signed [ibf_pkg::SAMPLE_W-1:0] r_y;

    logic signed [ibf_pkg::SAMPLE_W-1:0] w_data;
    logic signed [ibf_pkg::COEF_W-1:0]   w_coef;
    logic signed [32:0]                  w_op_a, w_op_b;
    logic signed [ibf_pkg::PROD_W-1:0]   w_prod;
    logic signed [ibf_pkg::PROD_W-1:0]   w_sc_sum;
    logic signed [ibf_pkg::SAMPLE_W-1:0] w_scaled;
    logic signed [ibf_pkg::ACC_W-1:0]    w_rnd;
    logic signed [ibf_pkg::SAMPLE_W-1:0] w_y;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ibf_pkg::MODE_BILINEAR;
            r_scale <= ibf_pkg::SCALE_RESET;
            r_ff01  <= '0;
            r_ff23  <= '0;
            r_ff4   <= '0;
            r_fb01  <= '0;
            r_fb23  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                ibf_pkg::REG_MODE:  r_mode  <= i_cfg_wr_data[0];
                ibf_pkg::REG_SCALE: r_scale <= i_cfg_wr_data[31:0];
                ibf_pkg::REG_FF01:  r_ff01  <= i_cfg_wr_data;
                ibf_pkg::REG_FF23:  r_ff23  <= i_cfg_wr_data;
                ibf_pkg::REG_FF4:   r_ff4   <= i_cfg_wr_data[31:0];
                ibf_pkg::REG_FB01:  r_fb01  <= i_cfg_wr_data;
                ibf_pkg::REG_FB23:  r_fb23  <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign o_sts.mode = r_mode;

    // tap operand selection
    always_comb begin
        w_data = '0;
        w_coef = '0;
        unique case (i_cmd.tap)
            ibf_pkg::TAP_FF0: begin w_data = r_in_hist[0];  w_coef = r_ff01[31:0];  end
            ibf_pkg::TAP_FF1: begin w_data = r_in_hist[1];  w_coef = r_ff01[63:32]; end
            ibf_pkg::TAP_FF2: begin w_data = r_in_hist[2];  w_coef = r_ff23[31:0];  end
            ibf_pkg::TAP_FF3: begin w_data = r_in_hist[3];  w_coef = r_ff23[63:32]; end
            ibf_pkg::TAP_FF4: begin w_data = r_in_hist[4];  w_coef = r_ff4;         end
            ibf_pkg::TAP_FB0: begin w_data = r_out_hist[0]; w_coef = r_fb01[31:0];  end
            ibf_pkg::TAP_FB1: begin w_data = r_out_hist[1]; w_coef = r_fb01[63:32]; end
            ibf_pkg::TAP_FB2: begin w_data = r_out_hist[2]; w_coef = r_fb23[31:0];  end
            ibf_pkg::TAP_FB3: begin w_data = r_out_hist[3]; w_coef = r_fb23[63:32]; end
            default: ;
        endcase
    end

    // one shared 33x33 signed multiplier; scale is unsigned so it gets a zero top bit
    assign w_op_a = i_cmd.mul_scale ? {r_x[31], r_x} : {w_data[31], w_data};
    assign w_op_b = i_cmd.mul_scale ? $signed({1'b0, r_scale}) : {w_coef[31], w_coef};
    assign w_prod = w_op_a * w_op_b;

    // round half up at bit 31, then saturate
    assign w_sc_sum = r_prod + (66'sd1 <<< 30);
    assign w_scaled = ibf_pkg::sat32({{5{w_sc_sum[65]}}, w_sc_sum[65:31]});

    // round half up to Q16.16, then saturate
    assign w_rnd = r_acc + (68'sd1 <<< (ibf_pkg::FRAC_SHIFT - 1));
    assign w_y   = ibf_pkg::sat32(w_rnd[ibf_pkg::ACC_W-1:ibf_pkg::FRAC_SHIFT]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.mul_scale || i_cmd.mul_tap) begin
            r_prod <= w_prod;
        end
        if (i_cmd.load_scaled) begin
            if (r_mode == ibf_pkg::MODE_MATCHED) begin
                r_acc <= {{8{w_scaled[31]}}, w_scaled, {ibf_pkg::FRAC_SHIFT{1'b0}}};
            end else begin
                r_acc <= '0;
            end
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + {{2{r_prod[65]}}, r_prod};
        end
        if (i_cmd.write_out) begin
            r_y <= w_y;
        end
    end

    // histories: plain shift lines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) r_in_hist[i] <= '0;
            for (int i = 0; i < 4; i++) r_out_hist[i] <= '0;
        end else begin
            if (i_cmd.load_scaled && r_mode == ibf_pkg::MODE_BILINEAR) begin
                for (int i = 0; i < 4; i++) r_in_hist[i] <= r_in_hist[i+1];
                r_in_hist[4] <= w_scaled;
            end
            if (i_cmd.write_out) begin
                for (int i = 0; i < 3; i++) r_out_hist[i] <= r_out_hist[i+1];
                r_out_hist[3] <= w_y;
            end
        end
    end

    assign o_sample_out = r_y;

`ifndef ASSERT_OFF
    a_one_mul_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.mul_scale && i_cmd.mul_tap))
        else $error("multiplier claimed by two steps at once");

    a_out_hist_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write_out |=> (r_out_hist[3] == r_y))
        else $error("output history and output register disagree");
`endif

endmodule

// File: bench/tb_iir_bessel_filter_order4.sv
// Self-checking bench for the fourth-order recursive filter: predicts and checks every output sample.
module tb_iir_bessel_filter_order4;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        COEF_STABLE,
        COEF_WILD,
        COEF_EXTREME
    } t_coef_kind;

    localparam logic [ibf_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam logic signed [31:0]   SAMPLE_MAX   = 32'sh7fff_ffff;
    localparam logic signed [31:0]   SAMPLE_MIN   = 32'sh8000_0000;
    localparam logic [31:0]          Q28_ONE      = 32'h1000_0000;
    localparam logic [31:0]          COEF_MAX     = 32'h7fff_ffff;
    localparam logic [31:0]          COEF_MIN     = 32'h8000_0000;
    localparam logic [31:0]          SCALE_MAX    = 32'hffff_ffff;
    localparam int                   DRAIN_CYCLES = 25;

    logic                                clk         = 1'b0;
    logic                                rst_n       = 1'b0;
    logic                                cfg_wr_en   = 1'b0;
    logic [ibf_pkg::CFG_IDX_W-1:0]       cfg_addr    = '0;
    logic [ibf_pkg::PAIR_W-1:0]          cfg_wr_data = '0;
    logic                                in_valid    = 1'b0;
    logic                                in_ready;
    logic signed [ibf_pkg::SAMPLE_W-1:0] sample_in   = '0;
    logic                                out_valid;
    logic                                out_ready   = 1'b0;
    logic signed [ibf_pkg::SAMPLE_W-1:0] sample_out;

    // filter state as the bench sees it
    logic               flt_mode;
    logic [31:0]        flt_scale;
    logic signed [31:0] ff_coef [5];
    logic signed [31:0] fb_coef [4];
    logic signed [31:0] x_hist [5];
    logic signed [31:0] y_hist [4];

    logic signed [31:0] expected_out [$];

    int gap_pct   = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int errors    = 0;

    iir_bessel_filter_order4 dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_sample_in   (sample_in),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_sample_out  (sample_out)
    );

    always #1 clk = ~clk;

    initial begin
        #1_000_000;
        $display("tb_iir_bessel_filter_order4: errors");
        $finish;
    end

    function automatic logic signed [79:0] wide(input logic signed [31:0] v);
        return 80'(v);
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [79:0] v);
        if (v > 80'sd2147483647) return SAMPLE_MAX;
        if (v < -80'sd2147483648) return SAMPLE_MIN;
        return v[31:0];
    endfunction

    task automatic clear_filter_state();
        int i;
        flt_mode  = ibf_pkg::MODE_BILINEAR;
        flt_scale = ibf_pkg::SCALE_RESET;
        for (i = 0; i < 5; i++) begin
            ff_coef[i] = '0;
            x_hist[i]  = '0;
        end
        for (i = 0; i < 4; i++) begin
            fb_coef[i] = '0;
            y_hist[i]  = '0;
        end
    endtask

    // Advance the filter by one sample and return the output it must produce.
    function automatic logic signed [31:0] filter_next(input logic signed [31:0] x);
        logic signed [79:0] acc;
        logic signed [31:0] scaled;
        logic signed [31:0] y;
        int i;
        acc    = wide(x) * $signed({48'd0, flt_scale}) + (80'sd1 <<< 30);
        scaled = clamp32(acc >>> 31);
        if (flt_mode == ibf_pkg::MODE_BILINEAR) begin
            for (i = 0; i < 4; i++) x_hist[i] = x_hist[i + 1];
            x_hist[4] = scaled;
            acc = '0;
            for (i = 0; i < 5; i++) acc += wide(x_hist[i]) * wide(ff_coef[i]);
        end else begin
            // input history holds still in matched-z mode
            acc = wide(scaled) <<< 28;
        end
        for (i = 0; i < 4; i++) acc += wide(y_hist[i]) * wide(fb_coef[i]);
        y = clamp32((acc + (80'sd1 <<< 27)) >>> 28);
        for (i = 0; i < 3; i++) y_hist[i] = y_hist[i + 1];
        y_hist[3] = y;
        return y;
    endfunction

    function automatic logic [31:0] pick_coef(input t_coef_kind kind, input int span_log2);
        case (kind)
            COEF_STABLE: return $urandom_range(2 << span_log2) - (1 << span_log2);
            COEF_WILD:   return $urandom();
            default:     return $urandom_range(1) ? COEF_MAX : COEF_MIN;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_sample();
        case ($urandom_range(7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3, 4: return $urandom();
            default: return $urandom_range(1 << 21) - (1 << 20);
        endcase
    endfunction

    task automatic write_reg(input logic [ibf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ibf_pkg::PAIR_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            ibf_pkg::REG_MODE:  flt_mode  = data[0];
            ibf_pkg::REG_SCALE: flt_scale = data[31:0];
            ibf_pkg::REG_FF01: begin
                ff_coef[0] = data[31:0];
                ff_coef[1] = data[63:32];
            end
            ibf_pkg::REG_FF23: begin
                ff_coef[2] = data[31:0];
                ff_coef[3] = data[63:32];
            end
            ibf_pkg::REG_FF4:   ff_coef[4] = data[31:0];
            ibf_pkg::REG_FB01: begin
                fb_coef[0] = data[31:0];
                fb_coef[1] = data[63:32];
            end
            ibf_pkg::REG_FB23: begin
                fb_coef[2] = data[31:0];
                fb_coef[3] = data[63:32];
            end
            default: ;
        endcase
    endtask

    // Write every register; unused upper bits carry junk that must be dropped.
    task automatic configure(input logic mode, input logic [31:0] scale,
                             input logic [4:0][31:0] ffc, input logic [3:0][31:0] fbc);
        logic [63:0] junk;
        junk = {$urandom(), $urandom()};
        write_reg(ibf_pkg::REG_MODE, {junk[63:1], mode});
        write_reg(ibf_pkg::REG_SCALE, {junk[63:32], scale});
        write_reg(ibf_pkg::REG_FF01, {ffc[1], ffc[0]});
        write_reg(ibf_pkg::REG_FF23, {ffc[3], ffc[2]});
        write_reg(ibf_pkg::REG_FF4, {junk[31:0], ffc[4]});
        write_reg(ibf_pkg::REG_FB01, {fbc[1], fbc[0]});
        write_reg(ibf_pkg::REG_FB23, {fbc[3], fbc[2]});
        write_reg(REG_UNMAPPED, junk);
    endtask

    task automatic configure_random(input t_coef_kind kind, input logic mode,
                                    input logic [31:0] scale);
        logic [4:0][31:0] ffc;
        logic [3:0][31:0] fbc;
        int i;
        for (i = 0; i < 5; i++) ffc[i] = pick_coef(kind, 28);
        // keep the feedback loop stable unless wild or extreme values are asked for
        for (i = 0; i < 4; i++) fbc[i] = pick_coef(kind, 25);
        configure(mode, scale, ffc, fbc);
    endtask

    task automatic send_sample(input logic signed [31:0] s);
        if ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        do @(posedge clk); while (!in_ready);
        expected_out.push_back(filter_next(s));
    endtask

    // Drop valid, then hold until every output has come back and the pipe is quiet.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk) begin : output_monitor
        logic signed [31:0] want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_out.size() == 0) begin
                    $display("%0t: unexpected output transaction, sample_out %0d",
                             $time, sample_out);
                    errors++;
                end else begin
                    want = expected_out.pop_front();
                    if (sample_out !== want) begin
                        $display("%0t: sample_out expected %0d actual %0d",
                                 $time, want, sample_out);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic test_reset_state();
        send_sample(SAMPLE_MAX);
        send_sample(-32'sd65536);
        wait_drain();
    endtask

    task automatic test_scale_extremes();
        configure(ibf_pkg::MODE_BILINEAR, SCALE_MAX, {Q28_ONE, 128'd0}, '0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(-32'sd1);
        send_sample(32'sd1);
        send_sample(32'sh0001_0000);
        wait_drain();
    endtask

    task automatic test_output_saturation();
        configure(ibf_pkg::MODE_BILINEAR, ibf_pkg::SCALE_RESET, {5{COEF_MAX}}, {4{COEF_MAX}});
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        wait_drain();
    endtask

    task automatic test_matched_mode();
        configure(ibf_pkg::MODE_MATCHED, SCALE_MAX, {5{Q28_ONE}},
                  {32'h0800_0000, 32'hfc00_0000, 32'h0200_0000, 32'hff00_0000});
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(32'sd0);
        send_sample(32'sh0003_0000);
        send_sample(-32'sd1);
        wait_drain();
    endtask

    // Input history must survive a stay in matched-z mode untouched.
    task automatic test_mode_switch();
        configure(ibf_pkg::MODE_BILINEAR, ibf_pkg::SCALE_RESET,
                  {32'h0800_0000, 32'hf000_0000, 32'h0400_0000, 32'h1000_0000, 32'h0200_0000},
                  {32'h0400_0000, 32'hfe00_0000, 32'h0100_0000, 32'h0080_0000});
        repeat (3) send_sample(pick_sample());
        wait_drain();
        write_reg(ibf_pkg::REG_MODE, {63'd0, ibf_pkg::MODE_MATCHED});
        repeat (2) send_sample(pick_sample());
        wait_drain();
        write_reg(ibf_pkg::REG_MODE, {63'd0, ibf_pkg::MODE_BILINEAR});
        repeat (3) send_sample(pick_sample());
        wait_drain();
    endtask

    task automatic run_phase(input t_coef_kind kind, input logic mode, input logic [31:0] scale,
                             input int gap, input int stall, input int count);
        configure_random(kind, mode, scale);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (count) send_sample(pick_sample());
        wait_drain();
        gap_pct   = 0;
        stall_pct = 0;
    endtask

    task automatic test_random_streams();
        run_phase(COEF_STABLE,  ibf_pkg::MODE_BILINEAR, ibf_pkg::SCALE_RESET, 0,  0,  70);
        run_phase(COEF_WILD,    ibf_pkg::MODE_BILINEAR, $urandom(),           79, 0,  60);
        run_phase(COEF_STABLE,  ibf_pkg::MODE_MATCHED,  $urandom(),           0,  79, 60);
        run_phase(COEF_STABLE,  ibf_pkg::MODE_BILINEAR, SCALE_MAX,            25, 25, 70);
        run_phase(COEF_WILD,    ibf_pkg::MODE_MATCHED,  $urandom(),           25, 25, 50);
        run_phase(COEF_EXTREME, ibf_pkg::MODE_BILINEAR, SCALE_MAX,            0,  0,  40);
        run_phase(COEF_STABLE,  ibf_pkg::MODE_BILINEAR, 32'd0,                25, 25, 30);
    endtask

    task automatic test_backpressure();
        configure_random(COEF_STABLE, ibf_pkg::MODE_BILINEAR, ibf_pkg::SCALE_RESET);
        gap_pct   = 0;
        stall_pct = 0;
        // block the output long enough for the input side to stall
        hold_left = 200;
        repeat (30) send_sample(pick_sample());
        wait_drain();
        repeat (30) send_sample(pick_sample());
        wait_drain();
    endtask

    initial begin
        clear_filter_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_scale_extremes();
        test_output_saturation();
        test_matched_mode();
        test_mode_switch();
        test_random_streams();
        test_backpressure();
        if (errors == 0) begin
            $display("tb_iir_bessel_filter_order4: clean");
        end else begin
            $display("tb_iir_bessel_filter_order4: errors");
        end
        $finish;
    end

endmodule

// File: iir_bessel_filter_order4.f
design/ibf_pkg.sv
design/ibf_ctrl.sv
design/ibf_dpath.sv
design/iir_bessel_filter_order4.sv
bench/tb_iir_bessel_filter_order4.sv
